FILE: src/size_weighted_cache_replacement_defines.svh
// ----------------------------------------------------------------------------
// Size-weighted cache assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SIZE_WEIGHTED_CACHE_REPLACEMENT_DEFINES_SVH
`define SIZE_WEIGHTED_CACHE_REPLACEMENT_DEFINES_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define SWC_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("swc assertion failed: same-cycle check");
// The consequent must hold in the cycle after the antecedent.
`define SWC_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("swc assertion failed: next-cycle check");
`else
`define SWC_ASSERT_SAME(lbl, ck, rs, ante, cons)
`define SWC_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

FILE: src/swc_pkg.sv
// ----------------------------------------------------------------------------
// Size-weighted cache package
// Shared widths, payload and slot types, and controller/datapath links.
// ----------------------------------------------------------------------------
package swc_pkg;

  localparam int SWC_DEPTH  = 16;
  localparam int ID_W       = 16;
  localparam int SIZE_W     = 16;
  localparam int STAMP_W    = 32;
  localparam int USES_W     = 16;
  localparam int CAP_W      = 20;
  localparam int MODE_W     = 2;
  localparam int TOTAL_W    = 21;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 20'd1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 1'b1;

  // Replacement policies; the unused code behaves as FIFO.
  localparam logic [MODE_W-1:0] POL_FIFO = 2'd0;
  localparam logic [MODE_W-1:0] POL_LRU  = 2'd1;
  localparam logic [MODE_W-1:0] POL_LFU  = 2'd2;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   item_id;
    logic [SIZE_W-1:0] item_size;
  } req_t;

  typedef struct packed {
    logic            hit;
    logic            evicted;
    logic [ID_W-1:0] evicted_id;
    logic            rejected;
    logic            last;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SIZE_W-1:0]  size;
    logic [STAMP_W-1:0] stamp;
    logic [USES_W-1:0]  uses;
  } slot_t;

  typedef enum logic [2:0] {
    RES_HIT    = 3'd0,
    RES_MISS   = 3'd1,
    RES_REJECT = 3'd2,
    RES_EVICT  = 3'd3,
    RES_CLOSE  = 3'd4
  } res_code_t;

  typedef struct packed {
    logic      load;
    logic      scan_start;
    logic      scan_victim;
    logic      refresh;
    logic      append;
    logic      shift_start;
    logic      emit;
    res_code_t code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_idle;
    logic shift_idle;
    logic found;
    logic is_insert;
    logic oversize;
    logic need_evict;
    logic out_free;
  } ctrl_stat_t;

endpackage

FILE: src/swc_stream_if.sv
// ----------------------------------------------------------------------------
// Size-weighted cache stream interface
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface swc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/swc_datapath.sv
// ----------------------------------------------------------------------------
// Size-weighted cache datapath
// Slot memory, scan and compaction engines, counters and result register.
// ----------------------------------------------------------------------------
module swc_datapath #(
  parameter int DEPTH = swc_pkg::SWC_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  swc_pkg::ctrl_cmd_t              cmd,
  output swc_pkg::ctrl_stat_t             stat,
  input  swc_pkg::req_t                   in_data,
  input  logic                            cfg_we,
  input  logic [swc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  output swc_pkg::rsp_t                   out_data,
  input  logic                            out_ready
);
  import swc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CAP_W-1:0]   capacity;
  logic [MODE_W-1:0]  policy;
  logic [STAMP_W-1:0] op_clock;
  logic [CW-1:0]      slot_count;
  logic [TOTAL_W-1:0] size_total;
  req_t               item;
  logic [STAMP_W-1:0] now;

  slot_t              mem [DEPTH];
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  slot_t              rd_data;
  logic               rd_valid;
  logic               sh_pend;
  logic [AW-1:0]      rd_idx;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  slot_t              wr_data;

  logic               scan_busy;
  logic               scan_victim;
  logic [AW-1:0]      scan_addr;
  logic               sh_busy;
  logic [AW-1:0]      sh_addr;

  logic               found;
  logic [AW-1:0]      found_idx;
  logic [USES_W-1:0]  found_uses;
  logic [SIZE_W-1:0]  found_size;
  logic [AW-1:0]      best_idx;
  logic [STAMP_W-1:0] best_key;
  logic [ID_W-1:0]    best_id;
  logic [SIZE_W-1:0]  best_size;

  logic [STAMP_W-1:0] rd_key;
  logic [USES_W-1:0]  uses_inc;
  logic [TOTAL_W-1:0] size_sum;
  rsp_t               rsp_next;

  // Ranking key of the entry coming out of memory; FIFO keeps slot zero.
  always_comb begin
    priority if (policy == POL_LRU) begin
      rd_key = rd_data.stamp;
    end else if (policy == POL_LFU) begin
      rd_key = STAMP_W'(rd_data.uses);
    end else begin
      rd_key = '0;
    end
  end

  assign uses_inc = (found_uses == '1) ? found_uses : found_uses + 1'b1;
  assign size_sum = size_total + TOTAL_W'(item.item_size);

  assign rd_en   = scan_busy | sh_busy;
  assign rd_addr = scan_busy ? scan_addr : sh_addr;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    priority if (sh_pend) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx - 1'b1;
    end else if (cmd.refresh) begin
      wr_en   = 1'b1;
      wr_addr = found_idx;
      wr_data = '{id: item.item_id, size: found_size, stamp: now, uses: uses_inc};
    end else if (cmd.append) begin
      wr_en   = 1'b1;
      wr_addr = AW'(slot_count);
      wr_data = '{id: item.item_id, size: item.item_size, stamp: now,
                  uses: USES_W'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Configuration, counters and sequencing of the scan and shift engines.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAPACITY_RESET;
      policy     <= POL_FIFO;
      op_clock   <= '0;
      slot_count <= '0;
      size_total <= '0;
      scan_busy  <= 1'b0;
      sh_busy    <= 1'b0;
      rd_valid   <= 1'b0;
      sh_pend    <= 1'b0;
      found      <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CAPACITY) begin
          capacity <= cfg_data[CAP_W-1:0];
        end else if (cfg_index == CFG_POLICY) begin
          policy <= cfg_data[MODE_W-1:0];
        end
      end

      if (cmd.load) begin
        op_clock <= op_clock + 1'b1;
      end

      rd_valid <= scan_busy;
      sh_pend  <= ~scan_busy & sh_busy;

      if (cmd.scan_start) begin
        scan_busy <= (slot_count != '0);
        found     <= 1'b0;
      end else if (scan_busy && ((CW'(scan_addr) + CW'(1)) == slot_count)) begin
        scan_busy <= 1'b0;
      end

      if (rd_valid && !scan_victim && !found && rd_data.id == item.item_id) begin
        found <= 1'b1;
      end

      // Removing the victim: the tail slides down one place, one entry a cycle.
      if (cmd.shift_start) begin
        slot_count <= slot_count - 1'b1;
        size_total <= size_total - TOTAL_W'(best_size);
        sh_busy    <= (CW'(best_idx) + CW'(1)) < slot_count;
      end else if (sh_busy && (CW'(sh_addr) == slot_count)) begin
        sh_busy <= 1'b0;
      end else if (cmd.append) begin
        slot_count <= slot_count + 1'b1;
        size_total <= size_sum;
      end
    end
  end

  // Payload registers of the engines.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
      now  <= op_clock;
    end
    if (cmd.scan_start) begin
      scan_addr   <= '0;
      scan_victim <= cmd.scan_victim;
    end else if (scan_busy) begin
      scan_addr <= scan_addr + 1'b1;
    end
    if (rd_en) begin
      rd_idx <= rd_addr;
    end
    if (cmd.shift_start) begin
      sh_addr <= best_idx + 1'b1;
    end else if (sh_busy && !scan_busy) begin
      sh_addr <= sh_addr + 1'b1;
    end
    if (rd_valid && !scan_victim && !found && rd_data.id == item.item_id) begin
      found_idx  <= rd_idx;
      found_uses <= rd_data.uses;
      found_size <= rd_data.size;
    end
    // Strict less-than keeps the earliest inserted entry on a tie.
    if (rd_valid && scan_victim && (rd_idx == '0 || rd_key < best_key)) begin
      best_idx  <= rd_idx;
      best_key  <= rd_key;
      best_id   <= rd_data.id;
      best_size <= rd_data.size;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    rsp_next = '0;
    unique case (cmd.code)
      RES_HIT: begin
        rsp_next.hit  = 1'b1;
        rsp_next.last = 1'b1;
      end
      RES_REJECT: begin
        rsp_next.rejected = 1'b1;
        rsp_next.last     = 1'b1;
      end
      RES_EVICT: begin
        rsp_next.evicted    = 1'b1;
        rsp_next.evicted_id = best_id;
      end
      default: begin
        rsp_next.last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= rsp_next;
    end
  end

  assign stat.scan_idle  = ~scan_busy & ~rd_valid;
  assign stat.shift_idle = ~sh_busy & ~sh_pend;
  assign stat.found      = found;
  assign stat.is_insert  = (item.kind == KIND_INSERT);
  assign stat.oversize   = CAP_W'(item.item_size) > capacity;
  assign stat.need_evict = (slot_count != '0) &&
                           ((slot_count == CW'(DEPTH)) || (size_sum > TOTAL_W'(capacity)));
  assign stat.out_free   = ~out_valid | out_ready;

endmodule

FILE: src/swc_ctrl.sv
// ----------------------------------------------------------------------------
// Size-weighted cache controller
// Sequences search, victim selection, eviction, append and result output.
// ----------------------------------------------------------------------------
module swc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  swc_pkg::ctrl_stat_t  stat,
  output swc_pkg::ctrl_cmd_t   cmd
);
  import swc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_CHECK  = 6'b000100,
    S_VSCAN  = 6'b001000,
    S_EMIT   = 6'b010000,
    S_SHIFT  = 6'b100000
  } state_t;

  state_t    state;
  state_t    state_next;
  res_code_t code;
  res_code_t code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= RES_CLOSE;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.code   = code;
    state_next = state;
    code_next  = code;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.scan_idle) begin
          priority if (stat.found) begin
            cmd.refresh = 1'b1;
            code_next   = RES_HIT;
            state_next  = S_EMIT;
          end else if (!stat.is_insert) begin
            code_next  = RES_MISS;
            state_next = S_EMIT;
          end else if (stat.oversize) begin
            code_next  = RES_REJECT;
            state_next = S_EMIT;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.need_evict) begin
          cmd.scan_start  = 1'b1;
          cmd.scan_victim = 1'b1;
          state_next      = S_VSCAN;
        end else begin
          cmd.append = 1'b1;
          code_next  = RES_CLOSE;
          state_next = S_EMIT;
        end
      end
      S_VSCAN: begin
        if (stat.scan_idle) begin
          code_next  = RES_EVICT;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (code == RES_EVICT) begin
            cmd.shift_start = 1'b1;
            state_next      = S_SHIFT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_SHIFT: begin
        if (stat.shift_idle) begin
          state_next = S_CHECK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/size_weighted_cache_replacement.sv
// ----------------------------------------------------------------------------
// Size-weighted cache replacement
// Content cache bounded by summed entry sizes, with FIFO, LRU or LFU eviction.
//
//   Channel  Direction  Payload
//   req      in         kind, item_id, item_size
//   rsp      out        hit, evicted, evicted_id, rejected, last
//   cfg      in         write enable, register index, write data
//
// The time of a lookup or a cached insert grows with N, the number of occupied
// slots, set by the sequential scan of the slot memory. Each eviction adds a
// victim scan of all N slots and a compaction of the slots above the victim,
// one entry a cycle. A stalled result holds the controller in place.
// Reset is synchronous and empties the cache with no clearing pass.
// ----------------------------------------------------------------------------
`include "size_weighted_cache_replacement_defines.svh"

module size_weighted_cache_replacement #(
  parameter int DEPTH = swc_pkg::SWC_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  swc_stream_if.sink                      req,
  swc_stream_if.source                    rsp,
  input  logic                            cfg_we,
  input  logic [swc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import swc_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  rsp_t       out_data;
  logic       out_valid;

  swc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swc_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (req.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_ready (rsp.ready)
  );

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  `SWC_ASSERT_SAME(a_emit_needs_room, clk, rst, cmd.emit, stat.out_free)
  `SWC_ASSERT_SAME(a_accept_when_quiet, clk, rst, req.valid && req.ready, stat.scan_idle && stat.shift_idle)
  `SWC_ASSERT_SAME(a_partial_is_evict, clk, rst, rsp.valid && !rsp.data.last, rsp.data.evicted && !rsp.data.hit && !rsp.data.rejected)
  `SWC_ASSERT_NEXT(a_busy_after_load, clk, rst, cmd.load, !req.ready)

endmodule
